// File: src/kspt_pkg.sv
// Shared types, codes and default sizes of the keyed signed position table.
package kspt_pkg;

  // Default table geometry.
  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned KeyBytesDef     = 8;

  // Width of the lot count and position fields.
  localparam int unsigned PosW = 64;
  // Width of the instrument key field on the ports.
  localparam int unsigned KeyPortW = 64;

  // Function codes.
  localparam logic FuncApply = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // Side codes; the two remaining codes are invalid.
  localparam logic [1:0] SideBuy  = 2'd0;
  localparam logic [1:0] SideSell = 2'd1;

  // A key whose first byte holds this value is rejected by an apply.
  localparam logic [7:0] ZeroByte = 8'h00;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StInvalid  = 2'd1,
    StCapacity = 2'd2,
    StOverflow = 2'd3
  } status_e;

endpackage

// File: src/kspt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module kspt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/keyed_signed_position_table_core.sv
// Top level of the keyed signed position table: control, key search and position update.
//
// The block keeps up to TABLE_ENTRIES signed 64-bit positions, each keyed by the low
// KEY_BYTES bytes of instrument_key_i. An item is accepted at a rising edge where start
// is high and busy is low; it is then worked on alone while busy stays high. The
// keys live in one RAM and the positions in another, both with a registered read.
// The key RAM is searched one stored entry per cycle: an item is taken in, the stored
// entries are looked at in order (at least one), and when the key is found the
// position is read and updated. Each item gives exactly one result, shown on
// status_o and position_o for a single cycle while done_o is high; the receiver
// cannot stall, so it must take the result in that cycle. A new item may be accepted
// in the same cycle that a result is shown. Reset empties the table by clearing the
// entry count; the RAM contents at or above that count are never used, so no
// clearing pass is needed.
module keyed_signed_position_table_core
  import kspt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned KEY_BYTES     = KeyBytesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   func_i,
  input  logic [KeyPortW-1:0]    instrument_key_i,
  input  logic [1:0]             side_i,
  input  logic signed [PosW-1:0] lot_count_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic signed [PosW-1:0] position_o
);

  // Only the low KEY_BYTES bytes take part in matching, so only they are stored.
  localparam int unsigned KeyW  = 8 * KEY_BYTES;
  localparam int unsigned AddrW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_ENTRIES + 1);

  // Controller states.
  localparam logic [1:0] StateIdle = 2'd0;
  localparam logic [1:0] StateScan = 2'd1;
  localparam logic [1:0] StatePos  = 2'd2;

  logic [1:0] state_q, state_d;

  // Item registers, loaded when an item is accepted.
  logic                   func_q;
  logic [KeyW-1:0]        key_q;
  logic [1:0]             side_q;
  logic signed [PosW-1:0] lots_q;

  // Search index and table fill count.
  logic [AddrW-1:0] idx_q, idx_d;
  logic [CntW-1:0]  count_q, count_d;

  // Result registers.
  logic                   done_q, done_d;
  status_e                status_q, status_d;
  logic signed [PosW-1:0] position_q, position_d;

  // RAM ports.
  logic             key_we;
  logic [AddrW-1:0] key_waddr, key_raddr;
  logic [KeyW-1:0]  key_rdata;
  logic             pos_we;
  logic [AddrW-1:0] pos_waddr;
  logic [PosW-1:0]  pos_wdata, pos_rdata;

  logic                   accept;
  logic                   invalid;
  logic [CntW-1:0]        idx_ext, idx_next;
  logic                   in_range, hit, more;
  logic                   full;
  logic signed [PosW-1:0] delta, cur, sum;
  logic                   ovf;

  assign accept = start && !busy;
  assign busy   = (state_q != StateIdle);

  // An apply is rejected for a zero first key byte, a lot count that is not positive,
  // or a side code other than buy or sell. A query never fails.
  assign invalid = (func_q == FuncApply) &&
                   ((key_q[7:0] == ZeroByte) || lots_q[PosW-1] || (lots_q == '0) ||
                    ((side_q != SideBuy) && (side_q != SideSell)));

  // The key read issued last cycle was for idx_q; the entry is live only below count_q.
  assign idx_ext  = CntW'(idx_q);
  assign idx_next = idx_ext + CntW'(1);
  assign in_range = (idx_ext < count_q);
  assign hit      = in_range && (key_rdata == key_q);
  assign more     = (idx_next < count_q);
  assign full     = (count_q == CntW'(TABLE_ENTRIES));

  // Signed add of the trade, with overflow taken from the operand and result signs.
  assign delta = (side_q == SideBuy) ? lots_q : -lots_q;
  assign cur   = pos_rdata;
  assign sum   = cur + delta;
  assign ovf   = ~(cur[PosW-1] ^ delta[PosW-1]) & (cur[PosW-1] ^ sum[PosW-1]);

  // Entry 0 is fetched while idle so that the search starts on the cycle after accept.
  assign key_raddr = (state_q == StateScan) ? idx_next[AddrW-1:0] : '0;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    count_d    = count_q;
    done_d     = 1'b0;
    status_d   = status_q;
    position_d = position_q;
    key_we     = 1'b0;
    key_waddr  = count_q[AddrW-1:0];
    pos_we     = 1'b0;
    pos_waddr  = idx_q;
    pos_wdata  = sum;

    case (state_q)
      StateIdle: begin
        if (accept) begin
          idx_d   = '0;
          state_d = StateScan;
        end
      end

      StateScan: begin
        if (invalid) begin
          done_d     = 1'b1;
          status_d   = StInvalid;
          position_d = '0;
          state_d    = StateIdle;
        end else if (hit) begin
          // The position read of this entry is already under way.
          state_d = StatePos;
        end else if (more) begin
          idx_d = idx_next[AddrW-1:0];
        end else begin
          // The key is not in the table.
          done_d  = 1'b1;
          state_d = StateIdle;
          if (func_q == FuncQuery) begin
            status_d   = StOk;
            position_d = '0;
          end else if (full) begin
            status_d   = StCapacity;
            position_d = '0;
          end else begin
            // Append: a fresh entry starts at zero, so its position is the delta,
            // which cannot overflow for a positive lot count.
            key_we     = 1'b1;
            pos_we     = 1'b1;
            pos_waddr  = count_q[AddrW-1:0];
            pos_wdata  = delta;
            count_d    = count_q + CntW'(1);
            status_d   = StOk;
            position_d = delta;
          end
        end
      end

      StatePos: begin
        done_d  = 1'b1;
        state_d = StateIdle;
        if (func_q == FuncQuery) begin
          status_d   = StOk;
          position_d = cur;
        end else if (ovf) begin
          status_d   = StOverflow;
          position_d = cur;
        end else begin
          pos_we     = 1'b1;
          status_d   = StOk;
          position_d = sum;
        end
      end

      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      key_q  <= instrument_key_i[KeyW-1:0];
      side_q <= side_i;
      lots_q <= lot_count_i;
    end
    idx_q      <= idx_d;
    status_q   <= status_d;
    position_q <= position_d;
  end

  // Stored keys.
  kspt_ram #(
    .WIDTH (KeyW),
    .DEPTH (TABLE_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_q),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // Stored positions; read at the entry under search, so a hit has its data next cycle.
  kspt_ram #(
    .WIDTH (PosW),
    .DEPTH (TABLE_ENTRIES)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (idx_q),
    .rdata_o (pos_rdata)
  );

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign position_o = position_q;

  // An accepted item always keeps the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("accepted item did not make the block busy");

  // A result is shown only as the block returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result shown while still busy");

  // Rejected and capacity results carry a zero position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o && ((status_q == StInvalid) || (status_q == StCapacity))
                   |-> (position_o == '0))
    else $error("failed apply returned a nonzero position");

  // The fill count never passes the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= CntW'(TABLE_ENTRIES))
    else $error("entry count exceeds table size");

  // The table only grows through a successful append, which also reports a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (count_q != $past(count_q)) |-> (done_o && (status_q == StOk)))
    else $error("entry count changed without an appended entry");

endmodule
